// ===== sv/rmsa_pkg.sv =====
// Shared constants and the controller state type for the running mean and
// deviation accumulator bank. No dependencies; all sv/ files but rmsa_ram use it.
package rmsa_pkg;

  localparam int unsigned SLOTS_DEF    = 256;
  localparam int unsigned SAMPLE_W_DEF = 32;
  localparam int unsigned SLOT_W       = 8;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned WIDE_W       = 128;
  localparam int unsigned MPLR_W       = 64;
  localparam int unsigned DEN_W        = COUNT_W + 1;
  localparam int unsigned ROOT_W       = 64;
  localparam int unsigned ITER_W       = 8;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIFF,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_MAG,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MN_GO,
    ST_MN_WAIT,
    ST_AB_GO,
    ST_AB_WAIT,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_WB
  } state_e;

endpackage

// ===== sv/rmsa_if.sv =====
// Valid/ready channel interfaces for the input samples and the results.
// Depend on rmsa_pkg for the fixed field widths.
interface rmsa_in_if #(
  parameter int unsigned SAMPLE_WIDTH = rmsa_pkg::SAMPLE_W_DEF
);
  logic                                valid;
  logic                                ready;
  logic [rmsa_pkg::SLOT_W-1:0]         slot;
  logic signed [SAMPLE_WIDTH-1:0]      sample;

  modport source (output valid, slot, sample, input ready);
  modport sink   (input valid, slot, sample, output ready);
endinterface

interface rmsa_out_if #(
  parameter int unsigned SAMPLE_WIDTH = rmsa_pkg::SAMPLE_W_DEF
);
  logic                                valid;
  logic                                ready;
  logic [rmsa_pkg::COUNT_W-1:0]        sample_count;
  logic signed [SAMPLE_WIDTH-1:0]      mean_value;
  logic [SAMPLE_WIDTH-1:0]             std_dev;

  modport source (output valid, sample_count, mean_value, std_dev, input ready);
  modport sink   (input valid, sample_count, mean_value, std_dev, output ready);
endinterface

// ===== sv/rmsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rmsa_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/rmsa_mul.sv =====
// Bit-serial saturating multiplier, one multiplier bit per cycle, MSB first.
// Depends on rmsa_pkg for widths.
module rmsa_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rmsa_pkg::WIDE_W-1:0]     mcand_i,
  input  logic [rmsa_pkg::MPLR_W-1:0]     mplier_i,  // MSB aligned
  input  logic [rmsa_pkg::ITER_W-1:0]     iters_i,
  output logic                            done_o,
  output logic [rmsa_pkg::WIDE_W-1:0]     prod_o
);
  localparam int unsigned WW = rmsa_pkg::WIDE_W;

  logic                              busy_q, done_q, sat_q;
  logic [rmsa_pkg::ITER_W-1:0]       cnt_q;
  logic [WW-1:0]                     mcand_q, acc_q;
  logic [rmsa_pkg::MPLR_W-1:0]       mplier_q;
  logic [WW+1:0]                     sum;

  // Horner step: acc = 2*acc + bit*mcand; any carry out means saturation.
  assign sum = {1'b0, acc_q, 1'b0}
             + {2'b00, (mplier_q[rmsa_pkg::MPLR_W-1] ? mcand_q : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rmsa_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
      sat_q    <= 1'b0;
    end else if (busy_q) begin
      acc_q    <= sum[WW-1:0];
      sat_q    <= sat_q | (sum[WW+1:WW] != 2'b00) | acc_q[WW-1];
      mplier_q <= mplier_q << 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = sat_q ? '1 : acc_q;
endmodule

// ===== sv/rmsa_div.sv =====
// Restoring bit-serial divider of a wide dividend by a count-sized divisor,
// one quotient bit per cycle. Depends on rmsa_pkg for widths.
module rmsa_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rmsa_pkg::WIDE_W-1:0]     num_i,  // MSB aligned
  input  logic [rmsa_pkg::DEN_W-1:0]      den_i,
  input  logic [rmsa_pkg::ITER_W-1:0]     iters_i,
  output logic                            done_o,
  output logic [rmsa_pkg::WIDE_W-1:0]     quot_o
);
  localparam int unsigned WW = rmsa_pkg::WIDE_W;
  localparam int unsigned DW = rmsa_pkg::DEN_W;

  logic                          busy_q, done_q;
  logic [rmsa_pkg::ITER_W-1:0]   cnt_q;
  logic [WW-1:0]                 num_q, quot_q;
  logic [DW-1:0]                 den_q, rem_q;
  logic [DW:0]                   rsh, diff;
  logic                          ge;

  assign rsh  = {rem_q, num_q[WW-1]};
  assign diff = rsh - {1'b0, den_q};
  assign ge   = rsh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rmsa_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits DW bits.
      rem_q  <= ge ? diff[DW-1:0] : rsh[DW-1:0];
      quot_q <= {quot_q[WW-2:0], ge};
      num_q  <= num_q << 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ===== sv/rmsa_sqrt.sv =====
// Digit-by-digit integer square root (floor) of a wide value, one root bit
// per cycle. Depends on rmsa_pkg for widths.
module rmsa_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rmsa_pkg::WIDE_W-1:0]     rad_i,
  output logic                            done_o,
  output logic [rmsa_pkg::ROOT_W-1:0]     root_o
);
  localparam int unsigned WW = rmsa_pkg::WIDE_W;
  localparam int unsigned RW = rmsa_pkg::ROOT_W;
  localparam int unsigned CW = $clog2(RW + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [WW-1:0]     rad_q;
  logic [RW-1:0]     root_q;
  logic [RW+1:0]     rem_q;   // remainder never exceeds twice the root
  logic [RW+3:0]     rsh, trial, diff;
  logic              ge;

  assign rsh   = {rem_q, rad_q[WW-1:WW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = rsh - trial;
  assign ge    = rsh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[RW+1:0] : rsh[RW+1:0];
      root_q <= {root_q[RW-2:0], ge};
      rad_q  <= rad_q << 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== sv/running_mean_std_accumulator_unit.sv =====
// Bank of SLOTS running-statistics accumulators (count, mean, population
// standard deviation), updated one sample at a time with Welford's method.
// Each input transfer names a slot (taken modulo SLOTS) and a signed
// fixed-point sample; one result transfer returns the slot's new count
// (saturating at 2^32-1), its mean (its step toward the sample rounded to
// nearest, ties away from zero) and its deviation (floor of the root of the
// truncated variance, saturating at the sample width). Items are processed
// one at a time, each passing through the bit-serial multiplier, divider
// and square root units, which run one after another. A new item is taken
// while the previous result still waits on the output register. After
// reset the block zeroes every slot of its state RAM and accepts no input
// meanwhile.
// Depends on rmsa_pkg, rmsa_if, rmsa_ram, rmsa_mul, rmsa_div and rmsa_sqrt.
module running_mean_std_accumulator_unit #(
  parameter int unsigned SLOTS        = rmsa_pkg::SLOTS_DEF,
  parameter int unsigned SAMPLE_WIDTH = rmsa_pkg::SAMPLE_W_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rmsa_in_if.sink         in_i,
  rmsa_out_if.source      out_o
);
  localparam int unsigned W      = SAMPLE_WIDTH;
  localparam int unsigned CW     = rmsa_pkg::COUNT_W;
  localparam int unsigned WW     = rmsa_pkg::WIDE_W;
  localparam int unsigned PW     = rmsa_pkg::MPLR_W;
  localparam int unsigned DW     = rmsa_pkg::DEN_W;
  localparam int unsigned IDXW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NSLOT  = 1 << rmsa_pkg::SLOT_W;
  // The mean numerator is |x - m| + (N+1)/2.
  localparam int unsigned MNW    = ((W > CW) ? W : CW) + 1;
  localparam int unsigned RAMW   = CW + 2 * W;

  rmsa_pkg::state_e state_q, state_d;

  // Slot index folded into the bank: a constant table built at elaboration.
  logic [IDXW-1:0] slot_map [NSLOT];
  for (genvar i = 0; i < NSLOT; i++) begin : g_slot_map
    assign slot_map[i] = IDXW'(i % SLOTS);
  end

  logic [IDXW-1:0]        clr_q, idx_q;
  logic signed [W-1:0]    x_q, m_q, m1_q;
  logic [CW-1:0]          n_q;
  logic [W-1:0]           sd_q, dmag_q, amag_q;
  logic                   dneg_q;
  logic [DW-1:0]          k_q;
  logic [WW-1:0]          p3_q, sum_q;
  logic                   out_vld_q;
  logic [CW-1:0]          out_cnt_q;
  logic signed [W-1:0]    out_mean_q;
  logic [W-1:0]           out_sd_q;

  // RAM word: {count, mean, deviation}.
  logic                   ram_we, ram_re;
  logic [IDXW-1:0]        ram_waddr;
  logic [RAMW-1:0]        ram_wdata, ram_rdata;

  logic                   mul_go, mul_done, div_go, div_done, sq_go, sq_done;
  logic [WW-1:0]          mul_a, mul_p, div_n, div_q;
  logic [PW-1:0]          mul_b;
  logic [rmsa_pkg::ITER_W-1:0] mul_it, div_it;
  logic [rmsa_pkg::ROOT_W-1:0] root;

  logic                   in_xfer, wb_go;
  logic signed [W:0]      dd, ad;
  logic [MNW-1:0]         mnum;
  logic [WW:0]            vsum;
  logic [CW-1:0]          n1;
  logic [W-1:0]           sd1;

  assign in_xfer = in_i.valid && in_i.ready;
  assign wb_go   = !out_vld_q || out_o.ready;

  // Signed differences carry one extra bit; their magnitudes fit W bits.
  assign dd   = {x_q[W-1], x_q} - {m_q[W-1], m_q};
  assign ad   = {x_q[W-1], x_q} - {m1_q[W-1], m1_q};
  assign mnum = MNW'(dmag_q) + MNW'(k_q >> 1);
  assign vsum = {1'b0, mul_p} + {1'b0, p3_q};
  assign n1   = (n_q == '1) ? n_q : n_q + 1'b1;
  assign sd1  = (|root[rmsa_pkg::ROOT_W-1:W]) ? '1 : root[W-1:0];

  // Controller: next state and unit launches.
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {n1, m1_q, sd1};
    mul_go      = 1'b0;
    div_go      = 1'b0;
    sq_go       = 1'b0;
    unique case (state_q)
      rmsa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == IDXW'(SLOTS - 1)) begin
          state_d = rmsa_pkg::ST_IDLE;
        end
      end
      rmsa_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = rmsa_pkg::ST_READ;
        end
      end
      rmsa_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = rmsa_pkg::ST_LOAD;
      end
      rmsa_pkg::ST_LOAD:   state_d = rmsa_pkg::ST_DIFF;
      rmsa_pkg::ST_DIFF:   state_d = rmsa_pkg::ST_MDIV_GO;
      rmsa_pkg::ST_MDIV_GO: begin
        div_go  = 1'b1;
        state_d = rmsa_pkg::ST_MDIV_WAIT;
      end
      rmsa_pkg::ST_MDIV_WAIT: if (div_done) state_d = rmsa_pkg::ST_MAG;
      rmsa_pkg::ST_MAG:    state_d = rmsa_pkg::ST_SQ_GO;
      rmsa_pkg::ST_SQ_GO: begin
        mul_go  = 1'b1;
        state_d = rmsa_pkg::ST_SQ_WAIT;
      end
      rmsa_pkg::ST_SQ_WAIT: if (mul_done) state_d = rmsa_pkg::ST_MN_GO;
      rmsa_pkg::ST_MN_GO: begin
        mul_go  = 1'b1;
        state_d = rmsa_pkg::ST_MN_WAIT;
      end
      rmsa_pkg::ST_MN_WAIT: if (mul_done) state_d = rmsa_pkg::ST_AB_GO;
      rmsa_pkg::ST_AB_GO: begin
        mul_go  = 1'b1;
        state_d = rmsa_pkg::ST_AB_WAIT;
      end
      rmsa_pkg::ST_AB_WAIT: if (mul_done) state_d = rmsa_pkg::ST_VDIV_GO;
      rmsa_pkg::ST_VDIV_GO: begin
        div_go  = 1'b1;
        state_d = rmsa_pkg::ST_VDIV_WAIT;
      end
      rmsa_pkg::ST_VDIV_WAIT: if (div_done) state_d = rmsa_pkg::ST_ROOT_GO;
      rmsa_pkg::ST_ROOT_GO: begin
        sq_go   = 1'b1;
        state_d = rmsa_pkg::ST_ROOT_WAIT;
      end
      rmsa_pkg::ST_ROOT_WAIT: if (sq_done) state_d = rmsa_pkg::ST_WB;
      rmsa_pkg::ST_WB: begin
        if (wb_go) begin
          ram_we  = 1'b1;
          state_d = rmsa_pkg::ST_IDLE;
        end
      end
      default: state_d = rmsa_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and divider. Multiplier and
  // dividend operands are MSB aligned so the units only shift by one.
  always_comb begin
    mul_a  = WW'(sd_q);
    mul_b  = {sd_q, {(PW - W){1'b0}}};
    mul_it = rmsa_pkg::ITER_W'(W);
    if (state_q == rmsa_pkg::ST_MN_GO) begin
      // The multiplier still holds sd*sd from the previous pass.
      mul_a  = mul_p;
      mul_b  = {n_q, {(PW - CW){1'b0}}};
      mul_it = rmsa_pkg::ITER_W'(CW);
    end else if (state_q == rmsa_pkg::ST_AB_GO) begin
      mul_a  = WW'(amag_q);
      mul_b  = {dmag_q, {(PW - W){1'b0}}};
    end
    if (state_q == rmsa_pkg::ST_VDIV_GO) begin
      div_n  = sum_q;
      div_it = rmsa_pkg::ITER_W'(WW);
    end else begin
      div_n  = {mnum, {(WW - MNW){1'b0}}};
      div_it = rmsa_pkg::ITER_W'(MNW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rmsa_pkg::ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rmsa_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == rmsa_pkg::ST_WB && wb_go) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers, loaded as the controller walks through an item.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q <= slot_map[in_i.slot];
      x_q   <= in_i.sample;
    end
    if (state_q == rmsa_pkg::ST_LOAD) begin
      n_q  <= ram_rdata[RAMW-1 -: CW];
      m_q  <= ram_rdata[2*W-1 -: W];
      sd_q <= ram_rdata[W-1:0];
    end
    if (state_q == rmsa_pkg::ST_DIFF) begin
      dneg_q <= dd[W];
      dmag_q <= dd[W] ? W'(-dd) : W'(dd);
      k_q    <= {1'b0, n_q} + 1'b1;
    end
    if (state_q == rmsa_pkg::ST_MDIV_WAIT && div_done) begin
      m1_q <= dneg_q ? m_q - W'(div_q) : m_q + W'(div_q);
    end
    if (state_q == rmsa_pkg::ST_MAG) begin
      amag_q <= ad[W] ? W'(-ad) : W'(ad);
    end
    if (state_q == rmsa_pkg::ST_MN_WAIT && mul_done) begin
      p3_q <= mul_p;
    end
    if (state_q == rmsa_pkg::ST_AB_WAIT && mul_done) begin
      sum_q <= vsum[WW] ? '1 : vsum[WW-1:0];
    end
    if (state_q == rmsa_pkg::ST_WB && wb_go) begin
      out_cnt_q  <= n1;
      out_mean_q <= m1_q;
      out_sd_q   <= sd1;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.sample_count = out_cnt_q;
  assign out_o.mean_value   = out_mean_q;
  assign out_o.std_dev      = out_sd_q;

  rmsa_ram #(
    .DATA_W (RAMW),
    .DEPTH  (SLOTS),
    .ADDR_W (IDXW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  rmsa_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .iters_i  (mul_it),
    .done_o   (mul_done),
    .prod_o   (mul_p)
  );

  rmsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_n),
    .den_i   (k_q),
    .iters_i (div_it),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  rmsa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_go),
    .rad_i   (div_q),
    .done_o  (sq_done),
    .root_o  (root)
  );
endmodule

// ===== verif/rmsa_checker.sv =====
// Scoreboard for the running mean and deviation accumulator bank: predicts each
// result from the accepted samples and compares it. It has no dependencies.
module rmsa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_slot_i,
  input  logic [31:0] in_sample_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_count_i,
  input  logic [31:0] out_mean_i,
  input  logic [31:0] out_dev_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mean;
    logic [31:0] dev;
  } stats_t;

  logic [31:0] count_mem [256];
  logic [31:0] mean_mem  [256];
  logic [31:0] dev_mem   [256];
  stats_t      stats_q[$];

  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c  = r | (64'd1 << i);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  // Welford update of one slot; the internal sum saturates at 128 bits.
  function automatic stats_t update_slot(input logic [7:0] idx, input logic [31:0] smp);
    longint      x, m, d, m1;
    logic [63:0] k, q, ad, ax, sdv, root;
    logic [31:0] n;
    logic [255:0] p, s;
    logic [127:0] sum, var_w;
    stats_t      r;
    n   = count_mem[idx];
    m   = longint'($signed(mean_mem[idx]));
    x   = longint'($signed(smp));
    sdv = {32'd0, dev_mem[idx]};
    k   = {32'd0, n} + 64'd1;
    d   = x - m;
    ad  = (d < 0) ? 64'(-d) : 64'(d);
    q   = (ad + k / 2) / k;
    m1  = (d < 0) ? m - longint'(q) : m + longint'(q);
    ax  = (x - m1 < 0) ? 64'(m1 - x) : 64'(x - m1);
    p   = {192'd0, ax} * {192'd0, ad};
    s   = {192'd0, sdv * sdv} * {224'd0, n};
    s   = s + p;
    sum = (s[255:128] != 0) ? {128{1'b1}} : s[127:0];
    var_w = sum / {64'd0, k};
    root  = isqrt128(var_w);
    r.count = (n == 32'hFFFF_FFFF) ? n : n + 32'd1;
    r.mean  = 32'(m1);
    r.dev   = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    count_mem[idx] = r.count;
    mean_mem[idx]  = r.mean;
    dev_mem[idx]   = r.dev;
    return r;
  endfunction

  assign pending_o = stats_q.size();

  // The prediction state is cleared while reset is held.
  always @(posedge clk_i) begin
    stats_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        count_mem[i] = '0;
        mean_mem[i]  = '0;
        dev_mem[i]   = '0;
      end
      stats_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        stats_q = {stats_q, update_slot(in_slot_i, in_sample_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected result count=%h mean=%h dev=%h", $time,
                   out_count_i, out_mean_i, out_dev_i);
          fail_count_o++;
        end else begin
          e = stats_q.pop_front();
          if (e.count !== out_count_i) begin
            $display("%0t: count expected %h actual %h", $time, e.count, out_count_i);
            fail_count_o++;
          end
          if (e.mean !== out_mean_i) begin
            $display("%0t: mean expected %h actual %h", $time, e.mean, out_mean_i);
            fail_count_o++;
          end
          if (e.dev !== out_dev_i) begin
            $display("%0t: deviation expected %h actual %h", $time, e.dev, out_dev_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_running_mean_std_accumulator_unit.sv =====
// Top of the accumulator bank testbench: clock, reset, sample stimulus and the
// verdict. Depends on rmsa_pkg, rmsa_if, the block and rmsa_checker.
module tb_running_mean_std_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   calm;        // no idling in the last part of the run
  bit   hold_off;    // long receiver stall requested by the sender process

  rmsa_in_if  #(.SAMPLE_WIDTH(32)) in_ch ();
  rmsa_out_if #(.SAMPLE_WIDTH(32)) out_ch ();

  running_mean_std_accumulator_unit #(.SLOTS(256), .SAMPLE_WIDTH(32)) dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch)
  );

  rmsa_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_slot_i(in_ch.slot), .in_sample_i(in_ch.sample),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_count_i(out_ch.sample_count), .out_mean_i(out_ch.mean_value),
    .out_dev_i(out_ch.std_dev),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit: about 1130 items plus stalls, taken several times over.
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one sample and hold it until the transfer happens. A random gap
  // may come first, with valid low for its whole length.
  task automatic send_sample(input logic [7:0] slot, input logic [31:0] smp);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.slot   <= slot;
    in_ch.sample <= smp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Random sample: mostly moderate values so the means settle, with some
  // full-range values and extremes mixed in.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 200)) - 100);
      default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long stall on request.
  initial begin
    bit long_done;
    long_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !long_done) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        long_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int waited;
    calm     = 1'b0;
    hold_off = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.slot   <= '0;
    in_ch.sample <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes on one slot, a fresh slot per sign, bit patterns.
    send_sample(8'd0,   32'h7FFF_FFFF);
    send_sample(8'd0,   32'h8000_0000);
    send_sample(8'd0,   32'h7FFF_FFFF);
    send_sample(8'd0,   32'h8000_0000);
    send_sample(8'd255, 32'h8000_0000);
    send_sample(8'd255, 32'h8000_0000);
    send_sample(8'd1,   32'h0000_0000);
    send_sample(8'd1,   32'h0000_0001);
    send_sample(8'd1,   32'hFFFF_FFFF);
    send_sample(8'd1,   32'h0000_0002);  // tie rounding on the mean
    send_sample(8'd2,   32'h0001_0000);
    send_sample(8'd2,   32'hFFFF_0000);
    send_sample(8'd170, 32'hAAAA_AAAA);
    send_sample(8'd85,  32'h5555_5555);
    send_sample(8'd85,  32'hAAAA_AAAA);
    send_sample(8'd3,   32'h0000_0003);
    send_sample(8'd3,   32'h0000_0003);
    send_sample(8'd3,   32'h0000_0004);

    // Sender pause until every expected result has come. The wait starts on a
    // clock edge so the checker has already recorded the last transfer.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Long receiver stall while the sender keeps offering items.
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_sample(8'($urandom_range(0, 255)), rand_sample());

    for (int i = 0; i < 1100; i++) begin
      if (i == 900) calm = 1'b1;
      // Most traffic on a few hot slots so counts and statistics build up.
      send_sample($urandom_range(0, 2) != 0 ? 8'($urandom_range(4, 11))
                                            : 8'($urandom_range(0, 255)),
                  rand_sample());
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== running_mean_std_accumulator_unit.f =====
sv/rmsa_pkg.sv
sv/rmsa_if.sv
sv/rmsa_ram.sv
sv/rmsa_mul.sv
sv/rmsa_div.sv
sv/rmsa_sqrt.sv
sv/running_mean_std_accumulator_unit.sv
verif/rmsa_checker.sv
verif/tb_running_mean_std_accumulator_unit.sv
